[rtl/bpfp_pkg.sv]
package bpfp_pkg;

  // Total frame length in bytes, header included (23 to 63).
  localparam int unsigned FRAME_BYTES = 29;

  // Header length and the frame byte that carries the beacon address.
  localparam int unsigned HDR_LEN = 5;
  localparam int unsigned ADDR_POS = 22;

  // First frame byte of each little-endian word.
  localparam int unsigned TIME_POS = 5;
  localparam int unsigned X_POS = 9;
  localparam int unsigned Y_POS = 13;

  localparam int unsigned COUNT_W = 6;
  localparam int unsigned HDR_IDX_W = 3;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [HDR_IDX_W-1:0] hdr_idx_t;

  // Expected header byte at a given header position.
  function automatic logic [7:0] header_byte(input hdr_idx_t idx);
    logic [7:0] val;
    unique case (idx)
      3'd0: val = 8'hFF;
      3'd1: val = 8'h47;
      3'd2: val = 8'h11;
      3'd3: val = 8'h00;
      3'd4: val = 8'h16;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

[rtl/beacon_position_frame_parser.sv]
// Beacon position frame parser.
// Input channel: rx_byte with rx_valid / rx_ready carries one received serial
// byte per transfer. The block hunts for the header FF 47 11 00 16; a wrong
// byte sends it back to the hunt and is dropped. The rest of the frame is
// collected up to FRAME_BYTES bytes in total.
// Output channel: res_valid / res_ready with beacon_address, time_ms, pos_x
// and pos_y. One result is presented per complete frame; no CRC is checked.
// Latency: the result is valid in the cycle after the last frame byte is
// transferred. Throughput: one byte per cycle while rx_ready is high, with the
// result held in its own register stage behind the byte counter and capture logic.
// While a result waits and res_ready is low, bytes keep flowing; only the last
// byte of the next frame is held off with rx_ready low until the waiting
// result is taken, and that byte can be transferred in the same cycle.
// Reset (rst, synchronous) clears the counters, the captures, the result and
// res_valid, and the block starts hunting for the first header byte.
module beacon_position_frame_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  logic               rx_valid,
  output logic               rx_ready,
  output logic [7:0]         beacon_address,
  output logic [31:0]        time_ms,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic               res_valid,
  input  logic               res_ready
);

  localparam bpfp_pkg::count_t LAST_COUNT =
    bpfp_pkg::COUNT_W'(bpfp_pkg::FRAME_BYTES);
  localparam bpfp_pkg::count_t HDR_COUNT = bpfp_pkg::COUNT_W'(bpfp_pkg::HDR_LEN);
  localparam bpfp_pkg::hdr_idx_t HDR_IDX_END =
    bpfp_pkg::HDR_IDX_W'(bpfp_pkg::HDR_LEN);

  bpfp_pkg::hdr_idx_t hdr_idx, hdr_idx_next;
  bpfp_pkg::count_t   count, count_next;
  bpfp_pkg::count_t   count_inc;
  logic [31:0]        time_capture, time_capture_next;
  logic [31:0]        x_capture, x_capture_next;
  logic [31:0]        y_capture, y_capture_next;
  logic [7:0]         address_capture, address_capture_next;
  logic               res_valid_next;
  logic               rx_xfer;
  logic               frame_done;
  logic               last_byte;
  logic [1:0]         lane;

  // Only the byte that completes a frame has to wait for a free result slot.
  assign last_byte = (count >= HDR_COUNT) && (count_inc == LAST_COUNT);
  assign rx_ready = !res_valid || res_ready || !last_byte;
  assign rx_xfer = rx_valid && rx_ready;
  assign count_inc = count + 1'b1;
  // All words start at a byte position congruent to 1 modulo 4.
  assign lane = count[1:0] - 2'd1;

  // Header hunt, byte counting and lane capture for one transferred byte.
  always_comb begin
    hdr_idx_next = hdr_idx;
    count_next = count;
    time_capture_next = time_capture;
    x_capture_next = x_capture;
    y_capture_next = y_capture;
    address_capture_next = address_capture;
    frame_done = 1'b0;
    if (rx_xfer) begin
      if (count >= HDR_COUNT) begin
        if (count >= LAST_COUNT) begin
          hdr_idx_next = '0;
          count_next = '0;
        end else begin
          if (count >= bpfp_pkg::COUNT_W'(bpfp_pkg::TIME_POS) &&
              count < bpfp_pkg::COUNT_W'(bpfp_pkg::X_POS)) begin
            time_capture_next[8*lane +: 8] = rx_byte;
          end else if (count >= bpfp_pkg::COUNT_W'(bpfp_pkg::X_POS) &&
                       count < bpfp_pkg::COUNT_W'(bpfp_pkg::Y_POS)) begin
            x_capture_next[8*lane +: 8] = rx_byte;
          end else if (count >= bpfp_pkg::COUNT_W'(bpfp_pkg::Y_POS) &&
                       count < bpfp_pkg::COUNT_W'(bpfp_pkg::Y_POS + 4)) begin
            y_capture_next[8*lane +: 8] = rx_byte;
          end else if (count == bpfp_pkg::COUNT_W'(bpfp_pkg::ADDR_POS)) begin
            address_capture_next = rx_byte;
          end
          if (count_inc == LAST_COUNT) begin
            hdr_idx_next = '0;
            count_next = '0;
            frame_done = 1'b1;
          end else begin
            count_next = count_inc;
          end
        end
      end else if (hdr_idx >= HDR_IDX_END) begin
        hdr_idx_next = '0;
        count_next = '0;
      end else if (rx_byte == bpfp_pkg::header_byte(hdr_idx)) begin
        hdr_idx_next = hdr_idx + 1'b1;
        count_next = count_inc;
      end else begin
        hdr_idx_next = '0;
        count_next = '0;
      end
    end
  end

  // Result handshake: set on a completed frame, cleared when taken.
  always_comb begin
    res_valid_next = res_valid;
    if (frame_done) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end
  end

  // State, capture and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_idx <= '0;
      count <= '0;
      time_capture <= '0;
      x_capture <= '0;
      y_capture <= '0;
      address_capture <= '0;
      res_valid <= 1'b0;
      beacon_address <= '0;
      time_ms <= '0;
      pos_x <= '0;
      pos_y <= '0;
    end else begin
      hdr_idx <= hdr_idx_next;
      count <= count_next;
      time_capture <= time_capture_next;
      x_capture <= x_capture_next;
      y_capture <= y_capture_next;
      address_capture <= address_capture_next;
      res_valid <= res_valid_next;
      // The completing byte may itself be a captured one, so load the next values.
      if (frame_done) begin
        beacon_address <= address_capture_next;
        time_ms <= time_capture_next;
        pos_x <= x_capture_next;
        pos_y <= y_capture_next;
      end
    end
  end

  // The header index never runs past the header length.
  assert property (@(posedge clk) disable iff (rst) hdr_idx <= HDR_IDX_END)
    else $error("header index beyond header length");

  // The byte counter stays below the frame length.
  assert property (@(posedge clk) disable iff (rst) count < LAST_COUNT)
    else $error("frame byte counter overran the frame length");

  // During the hunt the two counters advance together.
  assert property (@(posedge clk) disable iff (rst)
    count < HDR_COUNT |-> hdr_idx == count[bpfp_pkg::HDR_IDX_W-1:0])
    else $error("header index and byte counter disagree");

  // A new result always comes with the parser re-armed.
  assert property (@(posedge clk) disable iff (rst)
    frame_done |=> res_valid && count == '0 && hdr_idx == '0)
    else $error("result raised without re-arming the hunt");

endmodule
